@@ rtl/core/cnpm_pkg.sv @@
// Shared types and constants of the cube-net polar pixel map.
package cnpm_pkg;

    // Largest column count (four wall bands of block size) that a cube layout may use.
    localparam int unsigned MAX_COLUMN_CODE = 254;

    // Quotient bits produced by the division pipeline, one per stage.
    localparam int unsigned QUO_W = 8;

    // Configuration register indexes.
    localparam logic [2:0] REG_CUBE_MODE    = 3'd0;
    localparam logic [2:0] REG_BLOCK_SIZE   = 3'd1;
    localparam logic [2:0] REG_RIM_DEPTH    = 3'd2;
    localparam logic [2:0] REG_COLUMN_COUNT = 3'd3;
    localparam logic [2:0] REG_ROW_COUNT    = 3'd4;

    // How the angle column is formed from the first quotient.
    typedef enum logic [1:0] {
        COL_FIXED,
        COL_QUOT,
        COL_UP,
        COL_DOWN
    } col_sel_t;

    // Per-request control that travels alongside the divider operands.
    typedef struct packed {
        col_sel_t   col_sel;
        logic       dep_quot;
        logic [7:0] col_base;
        logic [7:0] dep_fixed;
        logic [5:0] limit;
        logic       gap;
    } side_t;

endpackage

@@ rtl/core/cnpm_div_pipe.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
module cnpm_div_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cnpm_pkg::side_t   in_side,
    input  logic [15:0]       in_num_a,
    input  logic [7:0]        in_den_a,
    input  logic [15:0]       in_num_b,
    input  logic [7:0]        in_den_b,
    output logic              out_valid,
    output cnpm_pkg::side_t   out_side,
    output logic [7:0]        out_quo_a,
    output logic [7:0]        out_quo_b
);
    import cnpm_pkg::*;

    // Numerator is below den*256, so the top byte is already a valid remainder.
    function automatic logic [15:0] div_step(input logic [15:0] w, input logic [7:0] d);
        logic [16:0] sh;
        logic [8:0]  top;
        logic [8:0]  diff;
        logic        qb;
        sh   = {w, 1'b0};
        top  = sh[16:8];
        qb   = (top >= {1'b0, d});
        diff = top - {1'b0, d};
        return {(qb ? diff[7:0] : top[7:0]), sh[7:1], qb};
    endfunction

    logic        v_reg [QUO_W];
    side_t       s_reg [QUO_W];
    logic [15:0] wa_reg [QUO_W];
    logic [15:0] wb_reg [QUO_W];
    logic [7:0]  da_reg [QUO_W];
    logic [7:0]  db_reg [QUO_W];

    logic [15:0] wa_next [QUO_W];
    logic [15:0] wb_next [QUO_W];

    always_comb
    begin
        wa_next[0] = div_step(in_num_a, in_den_a);
        wb_next[0] = div_step(in_num_b, in_den_b);
        for (int i = 1; i < QUO_W; i++)
        begin
            wa_next[i] = div_step(wa_reg[i-1], da_reg[i-1]);
            wb_next[i] = div_step(wb_reg[i-1], db_reg[i-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < QUO_W; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg[0]  <= in_side;
        da_reg[0] <= in_den_a;
        db_reg[0] <= in_den_b;
        wa_reg[0] <= wa_next[0];
        wb_reg[0] <= wb_next[0];
        for (int i = 1; i < QUO_W; i++)
        begin
            s_reg[i]  <= s_reg[i-1];
            da_reg[i] <= da_reg[i-1];
            db_reg[i] <= db_reg[i-1];
            wa_reg[i] <= wa_next[i];
            wb_reg[i] <= wb_next[i];
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_side  = s_reg[QUO_W-1];
    assign out_quo_a = wa_reg[QUO_W-1][7:0];
    assign out_quo_b = wb_reg[QUO_W-1][7:0];

endmodule

@@ rtl/core/cube_net_polar_map.sv @@
// Top level of the cube-net polar pixel map.
// Maps one LED matrix pixel per request to an angle column and a depth code,
// either as a flat bottom-up grid or as the net of an open cube (lid, four
// walls, gap corners). A request is taken on every clock at which start is
// high; busy is never raised. Each result appears on the result ports for one
// cycle with done high, in request order. A request passes through the input
// register, two decode stages, the 8-stage restoring divider (one quotient bit
// per stage) that serves the flat scaling and the lid edge interpolation, and
// the output register. Configuration writes take effect at once and must only
// be made while no request is in flight.
module cube_net_polar_map (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] pixel_x,
    input  logic [7:0] pixel_y,
    output logic       done,
    output logic [7:0] angle_column,
    output logic [7:0] depth_code,
    output logic       is_gap,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import cnpm_pkg::*;

    localparam logic [7:0] MAX_COL = 8'(MAX_COLUMN_CODE);

    // ---------------------------------------------------------------- config
    logic       cube_mode_reg;
    logic [5:0] block_size_reg;
    logic [5:0] rim_depth_reg;
    logic [7:0] column_count_reg;
    logic [7:0] row_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_mode_reg    <= 1'b1;
            block_size_reg   <= 6'd8;
            rim_depth_reg    <= 6'd4;
            column_count_reg <= 8'd24;
            row_count_reg    <= 8'd24;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CUBE_MODE:    cube_mode_reg    <= cfg_data[0];
                REG_BLOCK_SIZE:   block_size_reg   <= cfg_data[5:0];
                REG_RIM_DEPTH:    rim_depth_reg    <= cfg_data[5:0];
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Derived configuration; the user must keep it static while requests are in flight, the block does not enforce it.
    logic [5:0] blk;
    logic [5:0] bm1;
    logic [6:0] b2;
    logic [7:0] b3;
    logic [7:0] b3m1;
    logic [7:0] b4m1;
    logic       cube_en;
    logic [7:0] cols_eff;
    logic [7:0] row_den;

    assign blk      = (block_size_reg == 6'd0) ? 6'd1 : block_size_reg;
    assign bm1      = blk - 6'd1;
    assign b2       = {blk, 1'b0};
    assign b3       = {1'b0, b2} + {2'b0, blk};
    assign b3m1     = b3 - 8'd1;
    assign b4m1     = {blk, 2'b0} - 8'd1;
    assign cube_en  = cube_mode_reg && ({blk, 2'b0} <= MAX_COL);
    assign cols_eff = (column_count_reg == 8'd0) ? 8'd1 : column_count_reg;
    assign row_den  = (row_count_reg > 8'd1) ? row_count_reg - 8'd1 : 8'd1;

    assign busy = 1'b0;

    // ------------------------------------------------------ stage 0: capture
    logic       s0_valid_reg;
    logic [7:0] s0_x_reg;
    logic [7:0] s0_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s0_x_reg <= pixel_x;
        s0_y_reg <= pixel_y;
    end

    // ------------------------------------------------- stage 1: tile decode
    // Tile index by compare against b, 2b, 3b; a code of 3 is off the net.
    function automatic logic [1:0] tile_of(input logic [7:0] v, input logic [5:0] b,
                                           input logic [6:0] b2v, input logic [7:0] b3v);
        logic [1:0] t;
        if (v < {2'b0, b})
            t = 2'd0;
        else if (v < {1'b0, b2v})
            t = 2'd1;
        else if (v < b3v)
            t = 2'd2;
        else
            t = 2'd3;
        return t;
    endfunction

    function automatic logic [5:0] local_of(input logic [7:0] v, input logic [1:0] t,
                                            input logic [5:0] b, input logic [6:0] b2v);
        logic [7:0] r;
        case (t)
            2'd0:    r = v;
            2'd1:    r = v - {2'b0, b};
            default: r = v - {1'b0, b2v};
        endcase
        return r[5:0];
    endfunction

    logic       s1_valid_reg;
    logic [1:0] s1_bx_reg, s1_by_reg;
    logic [5:0] s1_lx_reg, s1_ly_reg;
    logic [7:0] s1_x_reg;
    logic       s1_sat_reg;
    logic       s1_num_pos_reg;
    logic [7:0] s1_num_reg;

    logic [1:0] bx_next, by_next;
    logic [9:0] row_num;

    assign bx_next = tile_of(s0_x_reg, blk, b2, b3);
    assign by_next = tile_of(s0_y_reg, blk, b2, b3);
    assign row_num = {2'b0, row_count_reg} - 10'd1 - {2'b0, s0_y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_bx_reg      <= bx_next;
        s1_by_reg      <= by_next;
        s1_lx_reg      <= local_of(s0_x_reg, bx_next, blk, b2);
        s1_ly_reg      <= local_of(s0_y_reg, by_next, blk, b2);
        s1_x_reg       <= s0_x_reg;
        s1_sat_reg     <= (s0_x_reg >= cols_eff);
        s1_num_pos_reg <= !row_num[9] && (row_num != 10'd0);
        s1_num_reg     <= row_num[7:0];
    end

    // -------------------------------------- stage 2: operands and side band
    logic signed [7:0] ax, ay;
    logic [5:0]        aax, aay, rad, den_l;
    logic signed [7:0] tsel;
    logic [7:0]        tplus;
    logic [12:0]       lid_num;
    logic              gap_t, lid_t;

    side_t       side_next;
    logic [15:0] num_a, num_b;
    logic [7:0]  den_a, den_b;

    always_comb
    begin
        ax    = $signed({1'b0, s1_lx_reg, 1'b0}) - $signed({2'b0, bm1});
        ay    = $signed({1'b0, s1_ly_reg, 1'b0}) - $signed({2'b0, bm1});
        aax   = ax[7] ? 6'(-ax) : ax[5:0];
        aay   = ay[7] ? 6'(-ay) : ay[5:0];
        rad   = (aax > aay) ? aax : aay;
        den_l = rad;
        tsel  = (aay > aax) ? ax : ay;
        tplus = 8'(tsel + $signed({2'b0, den_l}));
        lid_num = tplus[6:0] * blk;

        gap_t = (s1_bx_reg == 2'd3) || (s1_by_reg == 2'd3)
                || ((s1_bx_reg != 2'd1) && (s1_by_reg != 2'd1));
        lid_t = (s1_bx_reg == 2'd1) && (s1_by_reg == 2'd1);

        side_next.col_sel   = COL_FIXED;
        side_next.dep_quot  = 1'b0;
        side_next.col_base  = 8'd0;
        side_next.dep_fixed = 8'd0;
        side_next.limit     = bm1;
        side_next.gap       = 1'b0;
        num_a = 16'd0;
        den_a = 8'd1;
        num_b = 16'd0;
        den_b = 8'd1;

        if (!cube_en)
        begin
            // Flat grid: x and y go through the divider, save x past the columns and y at or above the top row.
            if (s1_sat_reg)
                side_next.col_base = 8'd255;
            else
            begin
                side_next.col_sel = COL_QUOT;
                num_a = {s1_x_reg, 8'd0};
                den_a = cols_eff;
            end
            if (s1_num_pos_reg)
            begin
                side_next.dep_quot = 1'b1;
                num_b = {s1_num_reg, 8'd0} - {8'd0, s1_num_reg};
                den_b = row_den;
            end
        end
        else if (gap_t)
        begin
            side_next.col_base = 8'd255;
            side_next.gap      = 1'b1;
        end
        else if (lid_t)
        begin
            side_next.dep_fixed = {3'd0, rad[5:1]};
            if (rad == 6'd0)
                side_next.col_base = 8'd0;
            else if (aay != aax)
            begin
                num_a = {3'd0, lid_num};
                den_a = {1'b0, den_l, 1'b0};
                if (aay > aax)
                begin
                    side_next.col_sel  = ay[7] ? COL_UP : COL_DOWN;
                    side_next.col_base = ay[7] ? 8'd0 : b3m1;
                end
                else
                begin
                    side_next.col_sel  = (!ax[7] && ax != 8'sd0) ? COL_UP : COL_DOWN;
                    side_next.col_base = (!ax[7] && ax != 8'sd0) ? {2'b0, blk} : b4m1;
                end
            end
            else if (ay[7])
                side_next.col_base = ax[7] ? 8'd0 : {2'b0, blk};
            else
                side_next.col_base = (!ax[7] && ax != 8'sd0) ? {1'b0, b2} : b3;
        end
        else
        begin
            // Walls: top, right, bottom, left bands of the ring.
            if (s1_by_reg == 2'd0)
            begin
                side_next.col_base  = {2'b0, s1_lx_reg};
                side_next.dep_fixed = {2'b0, rim_depth_reg} + {2'b0, bm1 - s1_ly_reg};
            end
            else if (s1_bx_reg == 2'd2)
            begin
                side_next.col_base  = {2'b0, blk} + {2'b0, s1_ly_reg};
                side_next.dep_fixed = {2'b0, rim_depth_reg} + {2'b0, s1_lx_reg};
            end
            else if (s1_by_reg == 2'd2)
            begin
                side_next.col_base  = b3m1 - {2'b0, s1_lx_reg};
                side_next.dep_fixed = {2'b0, rim_depth_reg} + {2'b0, s1_ly_reg};
            end
            else
            begin
                side_next.col_base  = b4m1 - {2'b0, s1_ly_reg};
                side_next.dep_fixed = {2'b0, rim_depth_reg} + {2'b0, bm1 - s1_lx_reg};
            end
        end
    end

    logic        s2_valid_reg;
    side_t       s2_side_reg;
    logic [15:0] s2_num_a_reg, s2_num_b_reg;
    logic [7:0]  s2_den_a_reg, s2_den_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg  <= side_next;
        s2_num_a_reg <= num_a;
        s2_den_a_reg <= den_a;
        s2_num_b_reg <= num_b;
        s2_den_b_reg <= den_b;
    end

    // -------------------------------------------------------- divide stages
    logic       dv_valid;
    side_t      dv_side;
    logic [7:0] dv_quo_a, dv_quo_b;

    cnpm_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_side   (s2_side_reg),
        .in_num_a  (s2_num_a_reg),
        .in_den_a  (s2_den_a_reg),
        .in_num_b  (s2_num_b_reg),
        .in_den_b  (s2_den_b_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo_a (dv_quo_a),
        .out_quo_b (dv_quo_b)
    );

    // ---------------------------------------------------- output assembly
    // Clamp the lid edge index to the last pixel of the side, then place it.
    logic [5:0] edge_k;
    logic [7:0] col_next;
    logic [7:0] dep_next;

    always_comb
    begin
        edge_k = (dv_quo_a > {2'b0, dv_side.limit}) ? dv_side.limit : dv_quo_a[5:0];
        case (dv_side.col_sel)
            COL_QUOT: col_next = dv_quo_a;
            COL_UP:   col_next = dv_side.col_base + {2'b0, edge_k};
            COL_DOWN: col_next = dv_side.col_base - {2'b0, edge_k};
            default:  col_next = dv_side.col_base;
        endcase
        dep_next = dv_side.dep_quot ? dv_quo_b : dv_side.dep_fixed;
    end

    logic       done_reg;
    logic [7:0] angle_column_reg;
    logic [7:0] depth_code_reg;
    logic       is_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        angle_column_reg <= col_next;
        depth_code_reg   <= dep_next;
        is_gap_reg       <= dv_side.gap;
    end

    assign done         = done_reg;
    assign angle_column = angle_column_reg;
    assign depth_code   = depth_code_reg;
    assign is_gap       = is_gap_reg;

`ifndef SYNTHESIS
    // Gap results carry the fixed gap codes.
    a_gap_col: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_gap |-> angle_column == 8'd255)
        else $error("gap result without gap column");

    a_gap_dep: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_gap |-> depth_code == 8'd0)
        else $error("gap result with non-zero depth");

    // Every result has a matching request that entered the divider.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s2_valid_reg, 9))
        else $error("result without matching request");
`endif

endmodule
